### rtl/core/iste_pkg.sv
// ----------------------------------------------------------------------------
// iste_pkg: shared types and codes for the integer set table engine
// Word layouts, opcodes, status codes and the controller/datapath command type.
// ----------------------------------------------------------------------------
package iste_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_MEMBER = 3'd2;
  localparam logic [2:0] OP_COUNT  = 3'd3;
  localparam logic [2:0] OP_SUBSET = 3'd4;
  localparam logic [2:0] OP_INTER  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               set_select;
    logic signed [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] element;
    logic               last;
    logic [5:0]         set_count;
    logic               set_empty;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture input word
    logic       rd_x;      // read X[xi]
    logic       rd_y;      // read Y[yi]
    logic       rd_f;      // read found list[fi]
    logic       wr_x;      // write X[count] <- key (append)
    logic       shift_x;   // write X[xi] <- X data reg (shift down)
    logic       push_f;    // append X data reg to found list
    logic       inc_cnt;
    logic       dec_cnt;
  } dp_cmd_t;

endpackage

### rtl/core/iste_datapath.sv
// ----------------------------------------------------------------------------
// iste_datapath: key stores and counts
// Two key memories, a found-key list, counts, and compare registers.
// ----------------------------------------------------------------------------
module iste_datapath import iste_pkg::*; #(
  parameter int SET_CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  input  in_word_t            in_word,
  input  logic [4:0]          xi,
  input  logic [4:0]          yi,
  input  logic [4:0]          fi,
  output in_word_t            cur,
  output logic [5:0]          xc,
  output logic [5:0]          yc,
  output logic [5:0]          fc,
  output logic signed [31:0]  xdata,
  output logic signed [31:0]  ydata,
  output logic signed [31:0]  fdata
);

  logic [31:0] mem_a [SET_CAPACITY];
  logic [31:0] mem_b [SET_CAPACITY];
  logic [31:0] mem_f [SET_CAPACITY];
  logic [5:0] count_a, count_b;
  logic [31:0] ra, rb;
  logic [31:0] wdata;
  logic [4:0] waddr;

  assign wdata = cmd.shift_x ? xdata : cur.key;
  // insert appends at the current count
  assign waddr = cmd.wr_x ? xc[4:0] : xi;

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_word;
    if (cmd.wr_x || cmd.shift_x) begin
      if (cur.set_select) mem_b[waddr] <= wdata;
      else mem_a[waddr] <= wdata;
    end
    if (cmd.push_f) mem_f[fc[4:0]] <= xdata;
    if (cmd.rd_f) fdata <= mem_f[fi];
    ra <= mem_a[cur.set_select ? yi : xi];
    rb <= mem_b[cur.set_select ? xi : yi];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_x) xdata <= cur.set_select ? rb : ra;
    if (cmd.rd_y) ydata <= cur.set_select ? ra : rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      fc <= '0;
    end else begin
      if (cmd.load) fc <= '0;
      else if (cmd.push_f) fc <= fc + 6'd1;
      if (cmd.inc_cnt) begin
        if (cur.set_select) count_b <= count_b + 6'd1;
        else count_a <= count_a + 6'd1;
      end else if (cmd.dec_cnt) begin
        if (cur.set_select) count_b <= count_b - 6'd1;
        else count_a <= count_a - 6'd1;
      end
    end
  end

  assign xc = cur.set_select ? count_b : count_a;
  assign yc = cur.set_select ? count_a : count_b;

endmodule

### rtl/core/iste_controller.sv
// ----------------------------------------------------------------------------
// iste_controller: operation sequencer
// Walks the key memories one entry per step and builds result words.
// ----------------------------------------------------------------------------
module iste_controller import iste_pkg::*; #(
  parameter int SET_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_word,
  output dp_cmd_t            cmd,
  input  in_word_t           cur,
  output logic [4:0]         xi,
  output logic [4:0]         yi,
  output logic [4:0]         fi,
  input  logic [5:0]         xc,
  input  logic [5:0]         yc,
  input  logic [5:0]         fc,
  input  logic signed [31:0] xdata,
  input  logic signed [31:0] ydata,
  input  logic signed [31:0] fdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_XRD   = 4'd2;  // memory read in flight for X
  localparam logic [3:0] S_XCHK  = 4'd3;  // X entry in xdata
  localparam logic [3:0] S_YRD   = 4'd4;
  localparam logic [3:0] S_YCHK  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_SHRD  = 4'd8;
  localparam logic [3:0] S_SHWR  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_ERD   = 4'd11;
  localparam logic [3:0] S_EOUT  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [3:0] S_XLAT  = 4'd14;
  localparam logic [3:0] S_EWAIT = 4'd15;

  logic [3:0] state;
  logic [5:0] xp, yp, fp;   // walk positions
  logic [1:0] lat;          // read pipeline step
  logic       hit;
  out_word_t  res;

  // shift reads the entry above the one being overwritten
  assign xi = (state == S_SHRD) ? xp[4:0] + 5'd1 : xp[4:0];
  assign yi = yp[4:0];
  assign fi = fp[4:0];
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_XRD:  cmd.rd_x = (lat == 2'd1);
      S_YRD:  cmd.rd_y = (lat == 2'd1);
      S_FRD:  cmd.rd_f = 1'b1;
      S_ERD:  cmd.rd_f = 1'b1;
      S_SHRD: cmd.rd_x = (lat == 2'd1);
      S_SHWR: cmd.shift_x = 1'b1;
      default: ;
    endcase
    if (state == S_DISP && cur.opcode == OP_INSERT && xc < 6'(SET_CAPACITY)) begin
      cmd.wr_x = 1'b1;
      cmd.inc_cnt = 1'b1;
    end
    if (state == S_FCHK && fp == fc) cmd.push_f = 1'b1;
    if (state == S_SHRD && lat == 2'd2 && xp + 6'd1 >= xc) cmd.dec_cnt = 1'b1;
  end

  function automatic out_word_t mk(input logic [1:0] st, input logic fnd,
                                   input logic [31:0] el, input logic lst,
                                   input logic [5:0] c);
    out_word_t w;
    w.status = st; w.found = fnd; w.element = el; w.last = lst;
    w.set_count = c; w.set_empty = (c == 6'd0);
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      lat <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.load) state <= S_DISP;
        S_DISP: begin
          lat <= '0;
          unique case (cur.opcode)
            OP_INSERT: begin
              res <= mk((xc < 6'(SET_CAPACITY)) ? ST_OK : ST_FULL, 1'b0, '0, 1'b1,
                        (xc < 6'(SET_CAPACITY)) ? xc + 6'd1 : xc);
              state <= S_OUT;
            end
            OP_DELETE, OP_MEMBER, OP_SUBSET, OP_INTER: begin
              if (cur.opcode == OP_SUBSET) xp <= 6'd0;
              else xp <= xc - 6'd1;
              if (xc == 6'd0) begin
                if (cur.opcode == OP_DELETE) res <= mk(ST_NOT_FOUND, 1'b0, '0, 1'b1, xc);
                else if (cur.opcode == OP_SUBSET) res <= mk(ST_OK, 1'b1, '0, 1'b1, xc);
                else if (cur.opcode == OP_INTER) res <= mk(ST_EMPTY, 1'b0, '0, 1'b1, xc);
                else res <= mk(ST_OK, 1'b0, '0, 1'b1, xc);
                state <= S_OUT;
              end else state <= S_XRD;
            end
            default: begin
              res <= mk(ST_OK, 1'b0, '0, 1'b1, xc);
              state <= S_OUT;
            end
          endcase
        end
        S_XRD: begin
          lat <= lat + 2'd1;
          if (lat == 2'd1) begin
            lat <= '0;
            state <= S_XCHK;
          end
        end
        S_XCHK: begin
          if (cur.opcode == OP_DELETE || cur.opcode == OP_MEMBER) begin
            if (xdata == cur.key) begin
              if (cur.opcode == OP_MEMBER) begin
                res <= mk(ST_OK, 1'b1, '0, 1'b1, xc);
                state <= S_OUT;
              end else begin
                lat <= '0;
                state <= S_SHRD;
              end
            end else if (xp == 6'd0) begin
              res <= mk(cur.opcode == OP_DELETE ? ST_NOT_FOUND : ST_OK, 1'b0, '0, 1'b1, xc);
              state <= S_OUT;
            end else begin
              xp <= xp - 6'd1;
              state <= S_XRD;
            end
          end else begin
            yp <= 6'd0;
            hit <= 1'b0;
            if (yc == 6'd0) state <= S_XLAT;
            else state <= S_YRD;
          end
        end
        S_YRD: begin
          lat <= lat + 2'd1;
          if (lat == 2'd1) begin
            lat <= '0;
            state <= S_YCHK;
          end
        end
        S_YCHK: begin
          if (ydata == xdata) begin
            hit <= 1'b1;
            state <= S_XLAT;
          end else if (yp + 6'd1 >= yc) state <= S_XLAT;
          else begin
            yp <= yp + 6'd1;
            state <= S_YRD;
          end
        end
        S_XLAT: begin
          // hit resolved for current X entry
          if (cur.opcode == OP_SUBSET) begin
            if (!hit) begin
              res <= mk(ST_OK, 1'b0, '0, 1'b1, xc);
              state <= S_OUT;
            end else if (xp + 6'd1 >= xc) begin
              res <= mk(ST_OK, 1'b1, '0, 1'b1, xc);
              state <= S_OUT;
            end else begin
              xp <= xp + 6'd1;
              state <= S_XRD;
            end
          end else if (hit) begin
            fp <= 6'd0;
            state <= (fc == 6'd0) ? S_FCHK : S_FRD;
          end else state <= S_EMIT;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (fp != fc && fdata == xdata) state <= S_EMIT;
          else if (fp == fc) state <= S_EMIT;
          else if (fp + 6'd1 == fc) begin
            fp <= fc;
            state <= S_FCHK;
          end else begin
            fp <= fp + 6'd1;
            state <= S_FRD;
          end
        end
        S_EMIT: begin
          // next X entry, or start output run (or empty result if none found)
          if (xp == 6'd0) begin
            fp <= 6'd0;
            if (fc == 6'd0) begin
              res <= mk(ST_EMPTY, 1'b0, '0, 1'b1, xc);
              state <= S_OUT;
            end else state <= S_ERD;
          end else begin
            xp <= xp - 6'd1;
            state <= S_XRD;
          end
        end
        S_ERD: state <= S_EOUT;
        S_EOUT: if (!out_valid) begin
          out_word <= mk(ST_OK, 1'b0, fdata, fp + 6'd1 == fc, xc);
          out_valid <= 1'b1;
          if (fp + 6'd1 == fc) state <= S_IDLE;
          else begin
            fp <= fp + 6'd1;
            state <= S_EWAIT;
          end
        end
        S_EWAIT: state <= S_ERD;
        S_SHRD: begin
          // move X[xp+1] down to X[xp] until top reached
          lat <= lat + 2'd1;
          if (lat == 2'd2) begin
            lat <= '0;
            if (xp + 6'd1 >= xc) begin
              res <= mk(ST_OK, 1'b0, '0, 1'b1, xc - 6'd1);
              state <= S_OUT;
            end else state <= S_SHWR;
          end
        end
        S_SHWR: begin
          xp <= xp + 6'd1;
          state <= S_SHRD;
        end
        S_OUT: if (!out_valid) begin
          out_word <= res;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/integer_set_table_engine_unit.sv
// ----------------------------------------------------------------------------
// integer_set_table_engine_unit: two-set key table engine
// Top level joining sequencer and key store datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one in_word (opcode, set_select, key); out_valid/
//   out_ready carry result words. Intersection yields a run of words, the
//   final one with last set; every other opcode yields one word.
//   One item is processed at a time. Insert, count and unused opcodes present
//   a single word without walking the key memories; member and delete scan X
//   one entry at a time, and delete then shifts the tail down one entry at a
//   time. Subset and intersection walk each X entry against Y until a match,
//   one compare at a time through the single read port of each key memory.
//   Intersection words then leave one by one.
//   Reset clears counts and control; key memories are not cleared, as
//   only entries below the count are read.
//   A stalled receiver holds the output register; the next item is taken
//   only after the last result word is accepted.
// ----------------------------------------------------------------------------
module integer_set_table_engine_unit import iste_pkg::*; #(
  parameter int SET_CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  dp_cmd_t cmd;
  in_word_t cur;
  logic [4:0] xi, yi, fi;
  logic [5:0] xc, yc, fc;
  logic signed [31:0] xdata, ydata, fdata;

  iste_datapath #(.SET_CAPACITY(SET_CAPACITY)) u_dp (
    .clk, .rst, .cmd, .in_word, .xi, .yi, .fi, .cur, .xc, .yc, .fc,
    .xdata, .ydata, .fdata
  );

  iste_controller #(.SET_CAPACITY(SET_CAPACITY)) u_ctl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_word, .cmd,
    .cur, .xi, .yi, .fi, .xc, .yc, .fc, .xdata, .ydata, .fdata
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    xc <= 6'(SET_CAPACITY)) else $error("count over capacity");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.set_empty == (out_word.set_count == 6'd0)))
    else $error("empty flag mismatch");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accepted while result pending");

endmodule

### sim/integer_set_table_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// integer_set_table_engine_unit_tb: self-checking bench for the set engine
// Feeds opcode/key words through a gap-inserting driver, predicts every result
// word from a behavioral copy of both key sets, and compares each output word
// as a whole against its prediction under random receiver stalls.
// ----------------------------------------------------------------------------
module integer_set_table_engine_unit_tb;
  import iste_pkg::*;

  localparam int CAP = 32;
  localparam int STALL_LIMIT = 40000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  integer_set_table_engine_unit #(.SET_CAPACITY(CAP)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always #10 clk = ~clk;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  logic signed [31:0] keys_a[$];
  logic signed [31:0] keys_b[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  hold_send = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit key_in(ref logic signed [31:0] s[$], input logic signed [31:0] k);
    foreach (s[i]) if (s[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic out_word_t mk(logic [1:0] st, logic f, logic signed [31:0] e,
                                   logic l, int cnt);
    out_word_t w;
    w.status = st; w.found = f; w.element = e; w.last = l;
    w.set_count = cnt[5:0]; w.set_empty = (cnt == 0);
    return w;
  endfunction

  // apply one word to the set copies and queue its results
  task automatic predict_sets(input in_word_t w);
    logic signed [31:0] xs[$];
    logic signed [31:0] ys[$];
    logic signed [31:0] hits[$];
    bit sub;
    bit done;
    xs = w.set_select ? keys_b : keys_a;
    ys = w.set_select ? keys_a : keys_b;
    case (w.opcode)
      OP_INSERT: begin
        if (xs.size() >= CAP) begin
          expected_results.push_back(mk(ST_FULL, 0, 0, 1, xs.size()));
        end else begin
          xs.push_back(w.key);
          expected_results.push_back(mk(ST_OK, 0, 0, 1, xs.size()));
        end
      end
      OP_DELETE: begin
        done = 0;
        for (int i = xs.size() - 1; i >= 0 && !done; i--) begin
          if (xs[i] == w.key) begin
            xs.delete(i);
            done = 1;
          end
        end
        expected_results.push_back(mk(done ? ST_OK : ST_NOT_FOUND, 0, 0, 1, xs.size()));
      end
      OP_MEMBER: expected_results.push_back(mk(ST_OK, key_in(xs, w.key), 0, 1, xs.size()));
      OP_SUBSET: begin
        sub = 1;
        foreach (xs[i]) if (!key_in(ys, xs[i])) sub = 0;
        expected_results.push_back(mk(ST_OK, sub, 0, 1, xs.size()));
      end
      OP_INTER: begin
        for (int i = xs.size() - 1; i >= 0; i--)
          if (key_in(ys, xs[i]) && !key_in(hits, xs[i])) hits.push_back(xs[i]);
        if (hits.size() == 0)
          expected_results.push_back(mk(ST_EMPTY, 0, 0, 1, xs.size()));
        foreach (hits[i])
          expected_results.push_back(mk(ST_OK, 0, hits[i], i == hits.size() - 1, xs.size()));
      end
      default: expected_results.push_back(mk(ST_OK, 0, 0, 1, xs.size()));
    endcase
    if (w.set_select) keys_b = xs; else keys_a = xs;
  endtask

  function automatic in_word_t word(logic [2:0] op, logic sel, logic signed [31:0] k);
    in_word_t w;
    w.opcode = op; w.set_select = sel; w.key = k;
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
    end else begin
      if (in_valid) predict_sets(in_word);
      if (send_gap > 0 || hold_send || pending_words.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
        send_gap <= rand_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_word);
          errors++;
        end else begin
          out_word_t e;
          e = expected_results.pop_front();
          if (out_word !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_word);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("integer_set_table_engine_unit_tb failed");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $signed($urandom_range(0, 11)) - 6;
    if (r < 8) return $signed($urandom());
    return r == 8 ? 32'sh7fffffff : 32'sh80000000;
  endfunction

  initial begin
    int op;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed
    pending_words.push_back(word(OP_INTER, 0, 0));
    pending_words.push_back(word(OP_SUBSET, 0, 0));
    pending_words.push_back(word(OP_DELETE, 1, 5));
    pending_words.push_back(word(OP_INSERT, 0, 32'sh7fffffff));
    pending_words.push_back(word(OP_INSERT, 0, 32'sh80000000));
    pending_words.push_back(word(OP_INSERT, 0, 32'sh7fffffff));
    pending_words.push_back(word(OP_INSERT, 1, 32'sh80000000));
    pending_words.push_back(word(OP_INSERT, 1, -1));
    pending_words.push_back(word(OP_MEMBER, 0, 32'sh80000000));
    pending_words.push_back(word(OP_MEMBER, 1, 7));
    pending_words.push_back(word(OP_SUBSET, 0, -1));
    pending_words.push_back(word(OP_SUBSET, 1, 0));
    pending_words.push_back(word(OP_INTER, 0, -1));
    pending_words.push_back(word(OP_INTER, 1, 3));
    pending_words.push_back(word(OP_DELETE, 0, 32'sh7fffffff));
    pending_words.push_back(word(OP_DELETE, 1, -1));
    pending_words.push_back(word(OP_COUNT, 0, -1));
    pending_words.push_back(word(3'd6, 1, 0));
    pending_words.push_back(word(3'd7, 0, -1));
    for (int i = 0; i < 34; i++) pending_words.push_back(word(OP_INSERT, 1, i));
    pending_words.push_back(word(OP_INTER, 1, 0));
    for (int i = 0; i < 33; i++) pending_words.push_back(word(OP_DELETE, 1, 31 - i));
    wait (pending_words.size() == 0);
    hold_send = 1;
    wait (!in_valid && expected_results.size() == 0);
    hold_send = 0;
    // random
    for (int i = 0; i < 183; i++) begin
      op = $urandom_range(0, 99);
      if (op < 35) op = OP_INSERT;
      else if (op < 55) op = OP_DELETE;
      else if (op < 70) op = OP_MEMBER;
      else if (op < 76) op = OP_COUNT;
      else if (op < 85) op = OP_SUBSET;
      else if (op < 97) op = OP_INTER;
      else op = $urandom_range(6, 7);
      pending_words.push_back(word(op[2:0], 1'($urandom_range(0, 1)), pick_key()));
    end
    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("integer_set_table_engine_unit_tb passed");
    end else begin
      $display("integer_set_table_engine_unit_tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/iste_pkg.sv
rtl/core/iste_datapath.sv
rtl/core/iste_controller.sv
rtl/core/integer_set_table_engine_unit.sv
sim/integer_set_table_engine_unit_tb.sv
